>>> rtl/emr_pkg.sv
// ---------------------------------------------------------------------------
// emr_pkg: shared constants and types
// Field widths, command codes and the structs passed between the core and
// the top level of the midpoint ellipse rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package emr_pkg;

  localparam int COORD_W    = 10;
  localparam int RADIUS_W   = 9;
  localparam int OUT_W      = COORD_W + 2;
  localparam int SQ_W       = 2 * RADIUS_W;
  localparam int OFFX_W     = COORD_W;
  localparam int OFFY_W     = RADIUS_W;
  localparam int TX_W       = OFFX_W + 1;
  localparam int PROD_W     = SQ_W + OFFX_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int DEC_W      = 42;
  localparam int MUL_A_W    = SQ_W + TX_W;
  localparam int MUL_B_W    = SQ_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int IN_FIELD_W = 2 * COORD_W + 2 * RADIUS_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [COORD_W-1:0]  center_x;
    logic [COORD_W-1:0]  center_y;
    logic [RADIUS_W-1:0] radius_x;
    logic [RADIUS_W-1:0] radius_y;
  } emr_cmd_t;

  typedef struct packed {
    logic idle;
    logic emit;
    logic last;
  } emr_status_t;

  typedef struct packed {
    logic [COORD_W-1:0] cen_x;
    logic [COORD_W-1:0] cen_y;
    logic [OFFX_W-1:0]  off_x;
    logic [OFFY_W-1:0]  off_y;
  } emr_pos_t;

endpackage

`default_nettype wire

>>> rtl/midpoint_ellipse_rasterizer.sv
// ---------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: midpoint ellipse point generator
// Stream front end with an output register around the ellipse core.
// ---------------------------------------------------------------------------
// Usage:
//   Input words carry a command in in_tuser. A start word (0) loads center
//   and radii and gives no output; each step word (1) gives one output word
//   with the four mirrored coordinates, out_tlast marking the final set.
//   A step word with no ellipse running is taken and dropped.
// Sequencing:
//   A step word is answered in the next cycle from the output register.
//   The core then updates the decision term in ST_UPD1 and ST_UPD2; a step
//   that crosses into region two also runs ST_T1 to ST_T6 and ST_RND.
//   A start runs ST_SQ_X to ST_INIT, ST_T1 to ST_T6 if region one is empty,
//   and ST_RND, the multiply sequence on the single shared multiplier.
// Reset:
//   rst_n low clears the sequencer; no ellipse is running afterwards.
// Stall:
//   A waiting output word holds. in_tready is low while the core is busy,
//   and also while an output word waits and out_tready is low.
// ---------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer
  import emr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // x_plus, x_minus, y_plus, y_minus
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output logic                       out_tlast
);

  emr_cmd_t                cmd;
  emr_status_t             status;
  emr_pos_t                pos;
  logic                    in_accept;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_last_r;
  logic signed [OUT_W-1:0] x_plus_r;
  logic signed [OUT_W-1:0] x_minus_r;
  logic signed [OUT_W-1:0] y_plus_r;
  logic signed [OUT_W-1:0] y_minus_r;

  assign cmd.command  = in_tuser;
  assign cmd.center_x = in_tdata[COORD_W-1:0];
  assign cmd.center_y = in_tdata[2*COORD_W-1:COORD_W];
  assign cmd.radius_x = in_tdata[2*COORD_W+RADIUS_W-1:2*COORD_W];
  assign cmd.radius_y = in_tdata[IN_FIELD_W-1:2*COORD_W+RADIUS_W];

  assign in_tready = status.idle && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  emr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_accept),
    .cmd       (cmd),
    .status    (status),
    .pos       (pos)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (status.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.emit) begin
      x_plus_r   <= OUT_W'(pos.cen_x) + OUT_W'(pos.off_x);
      x_minus_r  <= OUT_W'(pos.cen_x) - OUT_W'(pos.off_x);
      y_plus_r   <= OUT_W'(pos.cen_y) + OUT_W'(pos.off_y);
      y_minus_r  <= OUT_W'(pos.cen_y) - OUT_W'(pos.off_y);
      out_last_r <= status.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({y_minus_r, y_plus_r, x_minus_r, x_plus_r});

endmodule

`default_nettype wire

>>> rtl/emr_mul.sv
// ---------------------------------------------------------------------------
// emr_mul: shared multiplier
// Unsigned multiplier with a registered product, ready in the cycle after its operands.
// ---------------------------------------------------------------------------
`default_nettype none

module emr_mul
  import emr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] mul_a,
  input  wire logic [MUL_B_W-1:0] mul_b,
  output logic      [MUL_P_W-1:0] mul_p
);

  logic [MUL_P_W-1:0] mul_p_r;

  always_ff @(posedge clk) begin
    mul_p_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign mul_p = mul_p_r;

endmodule

`default_nettype wire

>>> rtl/emr_core.sv
// ---------------------------------------------------------------------------
// emr_core: ellipse sequencer and datapath
// Holds the ellipse state, walks the offsets on each step word and runs the
// starting-term computations through the shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module emr_core
  import emr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire emr_cmd_t    cmd,
  output emr_status_t      status,
  output emr_pos_t         pos
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'h0001,
    ST_SQ_X  = 14'h0002,
    ST_SQ_Y  = 14'h0004,
    ST_CROSS = 14'h0008,
    ST_INIT  = 14'h0010,
    ST_RND   = 14'h0020,
    ST_UPD1  = 14'h0040,
    ST_UPD2  = 14'h0080,
    ST_T1    = 14'h0100,
    ST_T2    = 14'h0200,
    ST_T3    = 14'h0400,
    ST_T4    = 14'h0800,
    ST_T5    = 14'h1000,
    ST_T6    = 14'h2000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      active_r, active_nxt;
  logic                      region_two_r, region_two_nxt;
  logic [COORD_W-1:0]        cen_x_r, cen_x_nxt;
  logic [COORD_W-1:0]        cen_y_r, cen_y_nxt;
  logic [RADIUS_W-1:0]       rx_r, rx_nxt;
  logic [RADIUS_W-1:0]       ry_r, ry_nxt;
  logic [SQ_W-1:0]           rad_x_sq_r, rad_x_sq_nxt;
  logic [SQ_W-1:0]           rad_y_sq_r, rad_y_sq_nxt;
  logic [OFFX_W-1:0]         off_x_r, off_x_nxt;
  logic [OFFY_W-1:0]         off_y_r, off_y_nxt;
  logic [PROD_W-1:0]         prod_x_r, prod_x_nxt;
  logic [PROD_W-1:0]         prod_y_r, prod_y_nxt;
  logic                      sel_a_r, sel_a_nxt;
  logic                      sel_b_r, sel_b_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [DEC_W-1:0]   acc_r, acc_nxt;
  logic signed [DEC_W-1:0]   dec_r, dec_nxt;

  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_P_W-1:0]        mul_p;

  logic                      is_idle;
  logic                      at_last;
  logic                      take_start;
  logic                      take_step;
  logic                      dec_neg;
  logic                      dec_zero;
  logic [TX_W-1:0]           tx;
  logic [OFFY_W-1:0]         ty;
  logic [PROD_W:0]           term_a;
  logic [PROD_W:0]           term_b;
  logic [SQ_W-1:0]           term_c;
  logic [1:0]                rnd_add;
  logic signed [DEC_W-1:0]   rnd_sum;

  emr_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  assign is_idle    = (state_r == ST_IDLE);
  assign at_last    = region_two_r && (off_y_r == '0);
  assign take_start = cmd_valid && (cmd.command == CMD_START);
  assign take_step  = cmd_valid && (cmd.command == CMD_STEP) && active_r;
  assign dec_neg    = dec_r[DEC_W-1];
  assign dec_zero   = (dec_r == '0);
  assign tx         = {off_x_r, 1'b1};
  assign ty         = (off_y_r != '0) ? off_y_r - OFFY_W'(1) : OFFY_W'(1);
  assign term_a     = sel_a_r ? {prod_x_r, 1'b0} : '0;
  assign term_b     = sel_b_r ? {prod_y_r, 1'b0} : '0;
  assign term_c     = region_two_r ? rad_x_sq_r : rad_y_sq_r;
  assign rnd_add    = acc_r[DEC_W-1] ? 2'd1 : 2'd2;
  assign rnd_sum    = acc_r + DEC_W'(rnd_add);

  assign status.idle = is_idle;
  assign status.emit = take_step;
  assign status.last = at_last;

  assign pos.cen_x = cen_x_r;
  assign pos.cen_y = cen_y_r;
  assign pos.off_x = off_x_r;
  assign pos.off_y = off_y_r;

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    region_two_nxt = region_two_r;
    cen_x_nxt      = cen_x_r;
    cen_y_nxt      = cen_y_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    rad_x_sq_nxt   = rad_x_sq_r;
    rad_y_sq_nxt   = rad_y_sq_r;
    off_x_nxt      = off_x_r;
    off_y_nxt      = off_y_r;
    prod_x_nxt     = prod_x_r;
    prod_y_nxt     = prod_y_r;
    sel_a_nxt      = sel_a_r;
    sel_b_nxt      = sel_b_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    dec_nxt        = dec_r;
    mul_a          = MUL_A_W'(rx_r);
    mul_b          = MUL_B_W'(rx_r);

    case (state_r)
      ST_IDLE: begin
        if (take_start) begin
          cen_x_nxt      = cmd.center_x;
          cen_y_nxt      = cmd.center_y;
          rx_nxt         = cmd.radius_x;
          ry_nxt         = cmd.radius_y;
          off_x_nxt      = '0;
          off_y_nxt      = cmd.radius_y;
          prod_x_nxt     = '0;
          active_nxt     = 1'b1;
          region_two_nxt = 1'b0;
          state_nxt      = ST_SQ_X;
        end else if (take_step) begin
          if (at_last) begin
            active_nxt = 1'b0;
          end else begin
            state_nxt = ST_UPD1;
            if (!region_two_r) begin
              off_x_nxt  = off_x_r + OFFX_W'(1);
              prod_x_nxt = prod_x_r + PROD_W'(rad_y_sq_r);
              sel_a_nxt  = 1'b1;
              sel_b_nxt  = !dec_neg;
              if (!dec_neg) begin
                off_y_nxt  = off_y_r - OFFY_W'(1);
                prod_y_nxt = prod_y_r - PROD_W'(rad_x_sq_r);
              end
            end else begin
              off_y_nxt  = off_y_r - OFFY_W'(1);
              prod_y_nxt = prod_y_r - PROD_W'(rad_x_sq_r);
              sel_b_nxt  = 1'b1;
              sel_a_nxt  = dec_neg || dec_zero;
              if (dec_neg || dec_zero) begin
                off_x_nxt  = off_x_r + OFFX_W'(1);
                prod_x_nxt = prod_x_r + PROD_W'(rad_y_sq_r);
              end
            end
          end
        end
      end
      ST_SQ_X: begin
        mul_a     = MUL_A_W'(rx_r);
        mul_b     = MUL_B_W'(rx_r);
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        rad_x_sq_nxt = mul_p[SQ_W-1:0];
        mul_a        = MUL_A_W'(ry_r);
        mul_b        = MUL_B_W'(ry_r);
        state_nxt    = ST_CROSS;
      end
      ST_CROSS: begin
        rad_y_sq_nxt = mul_p[SQ_W-1:0];
        mul_a        = MUL_A_W'(rad_x_sq_r);
        mul_b        = MUL_B_W'(ry_r);
        state_nxt    = ST_INIT;
      end
      ST_INIT: begin
        prod_y_nxt = mul_p[PROD_W-1:0];
        if (mul_p[PROD_W-1:0] != '0) begin
          acc_nxt   = (DEC_W'(rad_y_sq_r) << 2) + DEC_W'(rad_x_sq_r)
                      - (DEC_W'(mul_p[PROD_W-1:0]) << 2);
          state_nxt = ST_RND;
        end else begin
          state_nxt = ST_T1;
        end
      end
      ST_UPD1: begin
        sum_nxt   = SUM_W'(term_a) + SUM_W'(term_c) - SUM_W'(term_b);
        state_nxt = ST_UPD2;
      end
      ST_UPD2: begin
        dec_nxt = dec_r + {{(DEC_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
        if (!region_two_r && !(prod_x_r < prod_y_r)) begin
          state_nxt = ST_T1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_T1: begin
        mul_a     = MUL_A_W'(rad_y_sq_r);
        mul_b     = MUL_B_W'(tx);
        state_nxt = ST_T2;
      end
      ST_T2: begin
        mul_a     = mul_p[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(tx);
        state_nxt = ST_T3;
      end
      ST_T3: begin
        acc_nxt   = mul_p[DEC_W-1:0];
        mul_a     = MUL_A_W'(rad_x_sq_r);
        mul_b     = MUL_B_W'(ty);
        state_nxt = ST_T4;
      end
      ST_T4: begin
        mul_a     = mul_p[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(ty);
        state_nxt = ST_T5;
      end
      ST_T5: begin
        acc_nxt   = acc_r + (mul_p[DEC_W-1:0] << 2);
        mul_a     = MUL_A_W'(rad_x_sq_r);
        mul_b     = rad_y_sq_r;
        state_nxt = ST_T6;
      end
      ST_T6: begin
        acc_nxt        = acc_r - (mul_p[DEC_W-1:0] << 2);
        region_two_nxt = 1'b1;
        state_nxt      = ST_RND;
      end
      ST_RND: begin
        dec_nxt   = rnd_sum >>> 2;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= 1'b0;
      region_two_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      region_two_r <= region_two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cen_x_r    <= cen_x_nxt;
    cen_y_r    <= cen_y_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    rad_x_sq_r <= rad_x_sq_nxt;
    rad_y_sq_r <= rad_y_sq_nxt;
    off_x_r    <= off_x_nxt;
    off_y_r    <= off_y_nxt;
    prod_x_r   <= prod_x_nxt;
    prod_y_r   <= prod_y_nxt;
    sel_a_r    <= sel_a_nxt;
    sel_b_r    <= sel_b_nxt;
    sum_r      <= sum_nxt;
    acc_r      <= acc_nxt;
    dec_r      <= dec_nxt;
  end

`ifndef SYNTHESIS
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take_step && !at_last) |=> (state_r == ST_UPD1))
    else $error("step word did not start the decision update");

  a_region_one_order: assert property (@(posedge clk) disable iff (!rst_n)
    (is_idle && active_r && !region_two_r) |-> (prod_x_r < prod_y_r))
    else $error("idle in region one past the region boundary");

  a_off_y_down: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !take_start) |=> (off_y_r <= $past(off_y_r)))
    else $error("vertical offset grew without a start word");

  a_region_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (region_two_r && !take_start) |=> region_two_r)
    else $error("region two dropped without a start word");
`endif

endmodule

`default_nettype wire

>>> tb/emr_point_checker.sv
// ---------------------------------------------------------------------------
// emr_point_checker: point set scoreboard for the ellipse rasterizer
// Watches both stream channels. Each accepted input word runs through a
// local midpoint ellipse tracer that yields the expected point sets, and
// each accepted output word is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module emr_point_checker
  import emr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [OUT_W-1:0] x_plus;
    logic [OUT_W-1:0] x_minus;
    logic [OUT_W-1:0] y_plus;
    logic [OUT_W-1:0] y_minus;
    logic             last;
  } point_set_t;

  point_set_t  expected_points[$];
  logic        tracing;
  logic        lower_arc;
  logic [63:0] cx, cy, rx_sq, ry_sq, dx, dy, decision;

  function automatic logic [63:0] quarter_round(input logic [63:0] q);
    if (q[63]) begin
      return -((-q + 64'd2) >> 2);
    end
    return (q + 64'd2) >> 2;
  endfunction

  function automatic logic on_upper_arc();
    return (ry_sq * dx) < (rx_sq * dy);
  endfunction

  function automatic void start_lower_arc();
    logic [63:0] tx, ty, t;
    tx = 64'd2 * dx + 64'd1;
    ty = (dy > 64'd0) ? dy - 64'd1 : 64'd1;
    t = ry_sq * tx * tx + 64'd4 * rx_sq * ty * ty - 64'd4 * rx_sq * ry_sq;
    decision = quarter_round(t);
    lower_arc = 1'b1;
  endfunction

  function automatic void trace_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
    logic [63:0] rx, ry, sum_x, dif_x, sum_y, dif_y;
    point_set_t  p;
    if (cmd == CMD_START) begin
      cx = 64'(data[0 +: COORD_W]);
      cy = 64'(data[COORD_W +: COORD_W]);
      rx = 64'(data[2*COORD_W +: RADIUS_W]);
      ry = 64'(data[2*COORD_W+RADIUS_W +: RADIUS_W]);
      rx_sq = rx * rx;
      ry_sq = ry * ry;
      dx = 64'd0;
      dy = ry;
      tracing = 1'b1;
      lower_arc = 1'b0;
      if (on_upper_arc()) begin
        decision = quarter_round(64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq);
      end else begin
        start_lower_arc();
      end
    end else if (tracing) begin
      sum_x = cx + dx;
      dif_x = cx - dx;
      sum_y = cy + dy;
      dif_y = cy - dy;
      p.x_plus  = sum_x[OUT_W-1:0];
      p.x_minus = dif_x[OUT_W-1:0];
      p.y_plus  = sum_y[OUT_W-1:0];
      p.y_minus = dif_y[OUT_W-1:0];
      p.last    = lower_arc && (dy == 64'd0);
      expected_points.push_back(p);
      if (p.last) begin
        tracing = 1'b0;
      end else if (!lower_arc) begin
        dx = dx + 64'd1;
        if (decision[63]) begin
          decision = decision + 64'd2 * ry_sq * dx + ry_sq;
        end else begin
          dy = dy - 64'd1;
          decision = decision + 64'd2 * ry_sq * dx + ry_sq - 64'd2 * rx_sq * dy;
        end
        if (!on_upper_arc()) begin
          start_lower_arc();
        end
      end else begin
        dy = dy - 64'd1;
        if (!decision[63] && decision != 64'd0) begin
          decision = decision + rx_sq - 64'd2 * rx_sq * dy;
        end else begin
          dx = dx + 64'd1;
          decision = decision + 64'd2 * ry_sq * dx - 64'd2 * rx_sq * dy + rx_sq;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    if (fail_count < 40) begin
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    point_set_t want;
    if (!rst_n) begin
      expected_points.delete();
      tracing = 1'b0;
      lower_arc = 1'b0;
      cx = 64'd0;
      cy = 64'd0;
      rx_sq = 64'd0;
      ry_sq = 64'd0;
      dx = 64'd0;
      dy = 64'd0;
      decision = 64'd0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point set with none expected", out_tdata[0 +: OUT_W], '0);
        end else begin
          want = expected_points.pop_front();
          if (out_tdata[0 +: OUT_W] !== want.x_plus)
            report_mismatch("x_plus", out_tdata[0 +: OUT_W], want.x_plus);
          if (out_tdata[OUT_W +: OUT_W] !== want.x_minus)
            report_mismatch("x_minus", out_tdata[OUT_W +: OUT_W], want.x_minus);
          if (out_tdata[2*OUT_W +: OUT_W] !== want.y_plus)
            report_mismatch("y_plus", out_tdata[2*OUT_W +: OUT_W], want.y_plus);
          if (out_tdata[3*OUT_W +: OUT_W] !== want.y_minus)
            report_mismatch("y_minus", out_tdata[3*OUT_W +: OUT_W], want.y_minus);
          if (out_tlast !== want.last)
            report_mismatch("last", OUT_W'(out_tlast), OUT_W'(want.last));
        end
      end
      if (in_tvalid && in_tready) begin
        trace_word(in_tuser, in_tdata);
      end
    end
    outstanding = expected_points.size();
  end

endmodule

>>> tb/tb_midpoint_ellipse_rasterizer.sv
// ---------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer: stream test of the ellipse rasterizer
// Drives start and step words (directed extremes, then random ellipses,
// cut short or run to the last point set) through phases of sender gaps
// and receiver stalls, including one long receiver hold-off. A separate
// checker predicts and compares every output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_midpoint_ellipse_rasterizer;
  import emr_pkg::*;

  localparam int ITEM_TARGET = 1450;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = CMD_STEP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int   fail_count;
  int   outstanding;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   n_words = 0;
  int   n_last = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  midpoint_ellipse_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  emr_point_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      n_last <= 0;
    end else if (out_tvalid && out_tready && out_tlast) begin
      n_last <= n_last + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_shape(input int cx, input int cy,
                                                       input int rx, input int ry);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[0 +: COORD_W] = cx[COORD_W-1:0];
    w[COORD_W +: COORD_W] = cy[COORD_W-1:0];
    w[2*COORD_W +: RADIUS_W] = rx[RADIUS_W-1:0];
    w[2*COORD_W+RADIUS_W +: RADIUS_W] = ry[RADIUS_W-1:0];
    return w;
  endfunction

  function automatic logic [IN_DATA_W-1:0] noise_word();
    return pack_shape($urandom_range(1023), $urandom_range(1023),
                      $urandom_range(511), $urandom_range(511));
  endfunction

  function automatic int pick_radius();
    int s;
    s = $urandom_range(99);
    if (s < 80) return $urandom_range(12);
    if (s < 96) return $urandom_range(60);
    return $urandom_range(511);
  endfunction

  task automatic send_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_words++;
  endtask

  // start an ellipse, then step until its last point set shows up or the cut is hit
  task automatic trace_ellipse(input int cx, input int cy, input int rx, input int ry,
                               input int cut);
    int seen;
    int steps;
    send_word(CMD_START, pack_shape(cx, cy, rx, ry));
    seen = n_last;
    steps = 0;
    while (n_last == seen && (cut < 0 || steps < cut)) begin
      send_word(CMD_STEP, noise_word());
      steps++;
    end
  endtask

  initial begin
    int ph;
    int guard;
    int rx;
    int ry;
    int cut;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 76, 0, 16};
    stall_tab = '{0, 0, 76, 16};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_STEP, noise_word());
    trace_ellipse(1023, 1023, 511, 511, 4);
    trace_ellipse(0, 0, 0, 0, -1);
    trace_ellipse(0, 1023, 7, 0, -1);
    trace_ellipse(512, 0, 0, 6, -1);
    trace_ellipse(3, 1020, 2, 3, -1);
    send_word(CMD_STEP, noise_word());

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      if (ph == 0) hold_req <= 1'b1;
      while (n_words < (ph + 1) * ITEM_TARGET / 4) begin
        if ($urandom_range(99) < 5) send_word(CMD_STEP, noise_word());
        rx = pick_radius();
        ry = pick_radius();
        if ($urandom_range(19) == 0) rx = 0;
        if ($urandom_range(19) == 0) ry = 0;
        cut = ($urandom_range(99) < 8) ? $urandom_range(6) : -1;
        trace_ellipse($urandom_range(1023), $urandom_range(1023), rx, ry, cut);
      end
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/emr_pkg.sv
rtl/emr_mul.sv
rtl/emr_core.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/emr_point_checker.sv
tb/tb_midpoint_ellipse_rasterizer.sv
